@@ hdl/lavm_pkg.sv @@
`timescale 1ns / 1ps
// Shared types, codes and rounding helpers for the look-at view matrix block.
// Depends on nothing; every other file of the block imports it.
package lavm_pkg;

  typedef logic signed [31:0] q16_t;
  typedef logic signed [32:0] diff_t;

  // One queued pose: eye and up as given, aim minus eye, and the zero-forward class.
  typedef struct packed {
    q16_t [2:0]  eye;
    q16_t [2:0]  upv;
    diff_t [2:0] d;
    logic        fwd_zero;
  } pose_t;

  typedef enum logic [2:0] {
    BK_IDLE,
    BK_NSHIFT,
    BK_MAC,
    BK_POST,
    BK_SQRT,
    BK_DINIT,
    BK_DIV,
    BK_EMIT
  } bk_state_e;

  typedef enum logic [2:0] {
    MAC_SQ,
    MAC_CFU,
    MAC_CSF,
    MAC_DOT_S,
    MAC_DOT_U,
    MAC_DOT_F
  } mac_op_e;

  localparam int unsigned QUEUE_DEPTH = 2;
  localparam int unsigned ROOT_STEPS  = 32;
  localparam int unsigned DIV_STEPS   = 32;
  localparam logic [1:0]  LAST_COL    = 2'd3;
  localparam q16_t        ONE_Q16     = 32'sd65536;
  localparam logic [63:0] ROOT_BIT0   = 64'h4000_0000_0000_0000;

  function automatic logic signed [33:0] pick3(logic [1:0] i, logic signed [33:0] v0,
                                               logic signed [33:0] v1,
                                               logic signed [33:0] v2);
    logic signed [33:0] r;
    case (i)
      2'd0:    r = v0;
      2'd1:    r = v1;
      default: r = v2;
    endcase
    return r;
  endfunction

  // Round half away from zero, drop 14 fraction bits.
  function automatic logic signed [20:0] rsh14(logic signed [33:0] v);
    logic [33:0] m;
    logic [33:0] r;
    m = v[33] ? 34'(-v) : 34'(v);
    r = (m + 34'd8192) >> 14;
    return v[33] ? -$signed(r[20:0]) : $signed(r[20:0]);
  endfunction

  // Round half away from zero, drop 30 fraction bits.
  function automatic logic signed [38:0] rsh30(logic signed [67:0] v);
    logic [67:0] m;
    logic [67:0] r;
    m = v[67] ? 68'(-v) : 68'(v);
    r = (m + 68'd536870912) >> 30;
    return v[67] ? -$signed(r[38:0]) : $signed(r[38:0]);
  endfunction

  function automatic q16_t sat32(logic signed [39:0] v);
    q16_t r;
    if (v > $signed(40'h00_7FFF_FFFF)) begin
      r = 32'sh7FFF_FFFF;
    end else if (v < $signed(40'hFF_8000_0000)) begin
      r = 32'sh8000_0000;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

endpackage

@@ hdl/lavm_front.sv @@
`timescale 1ns / 1ps
// Front end: takes a pose, forms aim minus eye and flags a zero forward vector.
// Depends on lavm_pkg.
module lavm_front import lavm_pkg::*; (
  input  logic  start_i,
  input  q16_t  eye_x_i,
  input  q16_t  eye_y_i,
  input  q16_t  eye_z_i,
  input  q16_t  aim_x_i,
  input  q16_t  aim_y_i,
  input  q16_t  aim_z_i,
  input  q16_t  upvec_x_i,
  input  q16_t  upvec_y_i,
  input  q16_t  upvec_z_i,
  input  logic  q_full_i,
  output logic  busy_o,
  output logic  push_o,
  output pose_t pose_o
);

  assign busy_o = q_full_i;
  assign push_o = start_i && !q_full_i;

  always_comb begin
    pose_o.eye[0] = eye_x_i;
    pose_o.eye[1] = eye_y_i;
    pose_o.eye[2] = eye_z_i;
    pose_o.upv[0] = upvec_x_i;
    pose_o.upv[1] = upvec_y_i;
    pose_o.upv[2] = upvec_z_i;
    pose_o.d[0]   = 33'(aim_x_i) - 33'(eye_x_i);
    pose_o.d[1]   = 33'(aim_y_i) - 33'(eye_y_i);
    pose_o.d[2]   = 33'(aim_z_i) - 33'(eye_z_i);
    pose_o.fwd_zero = (aim_x_i == eye_x_i) && (aim_y_i == eye_y_i) && (aim_z_i == eye_z_i);
  end

endmodule

@@ hdl/lavm_queue.sv @@
`timescale 1ns / 1ps
// Two-entry pose queue between front end and back end.
// Depends on lavm_pkg.
module lavm_queue import lavm_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  push_i,
  input  pose_t pose_i,
  input  logic  pop_i,
  output logic  full_o,
  output logic  valid_o,
  output pose_t head_o
);

  pose_t      mem_q [QUEUE_DEPTH];
  logic       wptr_q, wptr_d;
  logic       rptr_q, rptr_d;
  logic [1:0] cnt_q, cnt_d;

  assign full_o  = (cnt_q == 2'(QUEUE_DEPTH));
  assign valid_o = (cnt_q != 2'd0);
  assign head_o  = mem_q[rptr_q];

  always_comb begin
    wptr_d = wptr_q;
    rptr_d = rptr_q;
    cnt_d  = cnt_q;
    if (push_i) begin
      wptr_d = !wptr_q;
    end
    if (pop_i) begin
      rptr_d = !rptr_q;
    end
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + 2'd1;
    end else if (pop_i && !push_i) begin
      cnt_d = cnt_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= 1'b0;
      rptr_q <= 1'b0;
      cnt_q  <= 2'd0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wptr_q] <= pose_i;
    end
  end

endmodule

@@ hdl/lavm_back.sv @@
`timescale 1ns / 1ps
// Back end: normalises, forms cross and dot products over one shared multiplier,
// a bit-serial square root and divider, then emits the four columns. Depends on lavm_pkg.
module lavm_back import lavm_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       q_valid_i,
  input  pose_t      pose_i,
  output logic       q_pop_o,
  output logic       result_valid_o,
  output logic [1:0] column_index_o,
  output q16_t       row0_value_o,
  output q16_t       row1_value_o,
  output q16_t       row2_value_o,
  output q16_t       row3_value_o,
  output logic       last_column_o,
  output logic       degenerate_o
);

  bk_state_e state_q, state_d;
  mac_op_e   op_q, op_d;
  logic [1:0] comp_q, comp_d;
  logic [5:0] cnt_q, cnt_d;
  logic       sel_q, sel_d;
  logic       deg_q, deg_d;

  logic [63:0]        mag_q [3];
  logic [63:0]        mag_d [3];
  logic               neg_q [3];
  logic               neg_d [3];
  q16_t               f_q [3];
  q16_t               f_d [3];
  q16_t               s_q [3];
  q16_t               s_d [3];
  logic signed [33:0] u_q [3];
  logic signed [33:0] u_d [3];
  q16_t               t_q [3];
  q16_t               t_d [3];

  logic signed [67:0] acc_q, acc_d, prod_q, prod_d;
  logic               pv_q, pv_d, pneg_q, pneg_d;
  logic [63:0]        x_q, x_d, res_q, res_d, rbit_q, rbit_d;
  logic [32:0]        len_q, len_d;
  logic [32:0]        rem_q, rem_d;
  logic [31:0]        nlo_q, nlo_d, quo_q, quo_d;

  logic       ov_q, ov_d, olast_q, olast_d, odeg_q, odeg_d;
  logic [1:0] ocol_q, ocol_d;
  q16_t       or0_q, or0_d, or1_q, or1_d, or2_q, or2_d, or3_q, or3_d;

  // operand views at the multiplier width: signed values sign-extended, magnitudes zero-extended
  logic signed [33:0] fe [3];
  logic signed [33:0] se [3];
  logic signed [33:0] ue [3];
  logic signed [33:0] ee [3];
  logic signed [33:0] ve [3];
  logic signed [33:0] me [3];
  logic signed [33:0] va [3];
  logic signed [33:0] vb [3];
  logic signed [33:0] mac_a, mac_b;
  logic               mac_neg;
  logic [1:0]         mac_n, ia, ib, j1, j2;

  logic [63:0] mmax;
  logic [63:0] rt;
  logic [63:0] x_n;
  logic [63:0] res_n;
  logic [33:0] dt;
  logic        qb;
  logic [31:0] quo_n;
  logic [61:0] num;
  logic signed [31:0] qs;
  logic signed [38:0] r30;
  logic        after_norm;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      fe[i] = 34'(f_q[i]);
      se[i] = 34'(s_q[i]);
      ue[i] = u_q[i];
      ee[i] = 34'(pose_i.eye[i]);
      ve[i] = 34'(pose_i.upv[i]);
      me[i] = $signed({2'b00, mag_q[i][31:0]});
    end
  end

  always_comb begin
    mmax = mag_q[0];
    if (mag_q[1] > mmax) begin
      mmax = mag_q[1];
    end
    if (mag_q[2] > mmax) begin
      mmax = mag_q[2];
    end
  end

  // operand selection for the shared multiplier
  always_comb begin
    j1 = (comp_q == 2'd2) ? 2'd0 : comp_q + 2'd1;
    j2 = (comp_q == 2'd0) ? 2'd2 : comp_q - 2'd1;
    va = me;
    vb = me;
    mac_n = 2'd3;
    ia = cnt_q[1:0];
    ib = cnt_q[1:0];
    mac_neg = 1'b0;
    case (op_q)
      MAC_SQ: begin
        va = me;
        vb = me;
      end
      MAC_CFU: begin
        va = fe;
        vb = ve;
      end
      MAC_CSF: begin
        va = se;
        vb = fe;
      end
      MAC_DOT_S: begin
        va = se;
        vb = ee;
      end
      MAC_DOT_U: begin
        va = ue;
        vb = ee;
      end
      MAC_DOT_F: begin
        va = fe;
        vb = ee;
      end
      default: begin
        va = me;
        vb = me;
      end
    endcase
    if (op_q == MAC_CFU || op_q == MAC_CSF) begin
      mac_n   = 2'd2;
      ia      = (cnt_q[1:0] == 2'd0) ? j1 : j2;
      ib      = (cnt_q[1:0] == 2'd0) ? j2 : j1;
      mac_neg = (cnt_q[1:0] != 2'd0);
    end
    mac_a = pick3(ia, va[0], va[1], va[2]);
    mac_b = pick3(ib, vb[0], vb[1], vb[2]);
  end

  // square root step and divider step
  always_comb begin
    rt = res_q + rbit_q;
    if (x_q >= rt) begin
      x_n   = x_q - rt;
      res_n = (res_q >> 1) + rbit_q;
    end else begin
      x_n   = x_q;
      res_n = res_q >> 1;
    end
    dt = {rem_q, nlo_q[31]};
    qb = (dt >= {1'b0, len_q});
    quo_n = {quo_q[30:0], qb};
    num = 62'({mag_q[comp_q][30:0], 30'd0}) + 62'(len_q[32:1]);
    qs  = neg_q[comp_q] ? -$signed(quo_n) : $signed(quo_n);
    r30 = rsh30(acc_q);
  end

  always_comb begin
    state_d = state_q;
    op_d    = op_q;
    comp_d  = comp_q;
    cnt_d   = cnt_q;
    sel_d   = sel_q;
    deg_d   = deg_q;
    mag_d   = mag_q;
    neg_d   = neg_q;
    f_d     = f_q;
    s_d     = s_q;
    u_d     = u_q;
    t_d     = t_q;
    acc_d   = acc_q;
    prod_d  = prod_q;
    pv_d    = 1'b0;
    pneg_d  = pneg_q;
    x_d     = x_q;
    res_d   = res_q;
    rbit_d  = rbit_q;
    len_d   = len_q;
    rem_d   = rem_q;
    nlo_d   = nlo_q;
    quo_d   = quo_q;
    q_pop_o = 1'b0;
    after_norm = 1'b0;
    ov_d    = 1'b0;
    ocol_d  = ocol_q;
    olast_d = 1'b0;
    odeg_d  = odeg_q;
    or0_d   = or0_q;
    or1_d   = or1_q;
    or2_d   = or2_q;
    or3_d   = or3_q;

    unique case (state_q)
      BK_IDLE: begin
        if (q_valid_i) begin
          deg_d  = pose_i.fwd_zero;
          comp_d = 2'd0;
          if (pose_i.fwd_zero) begin
            for (int i = 0; i < 3; i++) begin
              f_d[i] = '0;
              s_d[i] = '0;
              u_d[i] = '0;
              t_d[i] = '0;
            end
            state_d = BK_EMIT;
          end else begin
            for (int i = 0; i < 3; i++) begin
              neg_d[i] = pose_i.d[i][32];
              mag_d[i] = 64'(pose_i.d[i][32] ? 33'(-pose_i.d[i]) : 33'(pose_i.d[i]));
            end
            sel_d   = 1'b0;
            state_d = BK_NSHIFT;
          end
        end
      end

      BK_NSHIFT: begin
        if (mmax == 64'd0) begin
          deg_d = 1'b1;
          for (int i = 0; i < 3; i++) begin
            if (sel_q) begin
              s_d[i] = '0;
            end else begin
              f_d[i] = '0;
            end
          end
          after_norm = 1'b1;
        end else if (mmax[63:39] != '0) begin
          for (int i = 0; i < 3; i++) mag_d[i] = mag_q[i] >> 8;
        end else if (mmax[63:31] != '0) begin
          for (int i = 0; i < 3; i++) mag_d[i] = mag_q[i] >> 1;
        end else if (mmax[63:22] == '0) begin
          for (int i = 0; i < 3; i++) mag_d[i] = mag_q[i] << 8;
        end else if (mmax[63:30] == '0) begin
          for (int i = 0; i < 3; i++) mag_d[i] = mag_q[i] << 1;
        end else begin
          op_d    = MAC_SQ;
          cnt_d   = '0;
          acc_d   = '0;
          state_d = BK_MAC;
        end
      end

      BK_MAC: begin
        if (cnt_q < 6'(mac_n)) begin
          prod_d = mac_a * mac_b;
          pneg_d = mac_neg;
          pv_d   = 1'b1;
        end
        if (pv_q) begin
          acc_d = pneg_q ? acc_q - prod_q : acc_q + prod_q;
        end
        cnt_d = cnt_q + 6'd1;
        if (cnt_q == 6'(mac_n)) begin
          state_d = BK_POST;
        end
      end

      BK_POST: begin
        cnt_d   = '0;
        acc_d   = '0;
        state_d = BK_MAC;
        case (op_q)
          MAC_SQ: begin
            x_d     = acc_q[63:0];
            res_d   = '0;
            rbit_d  = ROOT_BIT0;
            state_d = BK_SQRT;
          end
          MAC_CFU: begin
            neg_d[comp_q] = acc_q[67];
            mag_d[comp_q] = acc_q[67] ? 64'(-acc_q) : acc_q[63:0];
            if (comp_q == 2'd2) begin
              sel_d   = 1'b1;
              state_d = BK_NSHIFT;
            end else begin
              comp_d = comp_q + 2'd1;
            end
          end
          MAC_CSF: begin
            u_d[comp_q] = 34'(r30);
            if (comp_q == 2'd2) begin
              op_d = MAC_DOT_S;
            end else begin
              comp_d = comp_q + 2'd1;
            end
          end
          MAC_DOT_S: begin
            t_d[0] = sat32(-40'(r30));
            op_d   = MAC_DOT_U;
          end
          MAC_DOT_U: begin
            t_d[1] = sat32(-40'(r30));
            op_d   = MAC_DOT_F;
          end
          default: begin
            t_d[2]  = sat32(40'(r30));
            comp_d  = 2'd0;
            state_d = BK_EMIT;
          end
        endcase
      end

      BK_SQRT: begin
        x_d    = x_n;
        res_d  = res_n;
        rbit_d = rbit_q >> 2;
        cnt_d  = cnt_q + 6'd1;
        if (cnt_q == 6'(ROOT_STEPS - 1)) begin
          len_d   = res_n[32:0];
          comp_d  = 2'd0;
          state_d = BK_DINIT;
        end
      end

      BK_DINIT: begin
        rem_d   = 33'(num[61:32]);
        nlo_d   = num[31:0];
        quo_d   = '0;
        cnt_d   = '0;
        state_d = BK_DIV;
      end

      BK_DIV: begin
        rem_d = qb ? 33'(dt - {1'b0, len_q}) : dt[32:0];
        nlo_d = nlo_q << 1;
        quo_d = quo_n;
        cnt_d = cnt_q + 6'd1;
        if (cnt_q == 6'(DIV_STEPS - 1)) begin
          if (sel_q) begin
            s_d[comp_q] = qs;
          end else begin
            f_d[comp_q] = qs;
          end
          if (comp_q == 2'd2) begin
            after_norm = 1'b1;
          end else begin
            comp_d  = comp_q + 2'd1;
            state_d = BK_DINIT;
          end
        end
      end

      BK_EMIT: begin
        ov_d   = 1'b1;
        ocol_d = comp_q;
        odeg_d = deg_q;
        if (comp_q == LAST_COL) begin
          or0_d   = t_q[0];
          or1_d   = t_q[1];
          or2_d   = t_q[2];
          or3_d   = ONE_Q16;
          olast_d = 1'b1;
          q_pop_o = 1'b1;
          state_d = BK_IDLE;
        end else begin
          or0_d  = 32'(rsh14(pick3(comp_q, se[0], se[1], se[2])));
          or1_d  = 32'(rsh14(pick3(comp_q, ue[0], ue[1], ue[2])));
          or2_d  = -32'(rsh14(pick3(comp_q, fe[0], fe[1], fe[2])));
          or3_d  = '0;
          comp_d = comp_q + 2'd1;
        end
      end

      default: begin
        state_d = BK_IDLE;
      end
    endcase

    // start the cross product that follows a finished normalisation
    if (after_norm) begin
      op_d    = sel_q ? MAC_CSF : MAC_CFU;
      comp_d  = 2'd0;
      cnt_d   = '0;
      acc_d   = '0;
      state_d = BK_MAC;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= BK_IDLE;
      op_q    <= MAC_SQ;
      comp_q  <= 2'd0;
      cnt_q   <= '0;
      sel_q   <= 1'b0;
      deg_q   <= 1'b0;
      pv_q    <= 1'b0;
      ov_q    <= 1'b0;
      olast_q <= 1'b0;
      odeg_q  <= 1'b0;
      ocol_q  <= 2'd0;
    end else begin
      state_q <= state_d;
      op_q    <= op_d;
      comp_q  <= comp_d;
      cnt_q   <= cnt_d;
      sel_q   <= sel_d;
      deg_q   <= deg_d;
      pv_q    <= pv_d;
      ov_q    <= ov_d;
      olast_q <= olast_d;
      odeg_q  <= odeg_d;
      ocol_q  <= ocol_d;
    end
  end

  always_ff @(posedge clk_i) begin
    mag_q  <= mag_d;
    neg_q  <= neg_d;
    f_q    <= f_d;
    s_q    <= s_d;
    u_q    <= u_d;
    t_q    <= t_d;
    acc_q  <= acc_d;
    prod_q <= prod_d;
    pneg_q <= pneg_d;
    x_q    <= x_d;
    res_q  <= res_d;
    rbit_q <= rbit_d;
    len_q  <= len_d;
    rem_q  <= rem_d;
    nlo_q  <= nlo_d;
    quo_q  <= quo_d;
    or0_q  <= or0_d;
    or1_q  <= or1_d;
    or2_q  <= or2_d;
    or3_q  <= or3_d;
  end

  assign result_valid_o = ov_q;
  assign column_index_o = ocol_q;
  assign row0_value_o   = or0_q;
  assign row1_value_o   = or1_q;
  assign row2_value_o   = or2_q;
  assign row3_value_o   = or3_q;
  assign last_column_o  = olast_q;
  assign degenerate_o   = odeg_q;

endmodule

@@ hdl/look_at_view_matrix.sv @@
`timescale 1ns / 1ps
// Right-handed look-at view matrix in Q16.16. A pose is taken when start_i is high and
// busy_o is low; the queue holds two poses, the one being worked on and one waiting, so
// busy_o rises once a second pose waits behind the current one. Each pose gives four column
// items on consecutive cycles, each marked by result_valid_o for one cycle, column 3 carrying
// last_column_o; the receiver must take them as they come. A pose's time in the back end
// is set by the two normalisations: each runs a 32-step bit-serial square root and three
// 32-step bit-serial divisions, plus scaling shifts. A pose whose up vector is parallel to
// the view line skips the second normalisation; a pose with aim equal to eye skips all of
// that and goes straight to emitting its columns.
// Depends on lavm_pkg, lavm_front, lavm_queue and lavm_back.
module look_at_view_matrix import lavm_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       start_i,
  output logic       busy_o,
  input  q16_t       eye_x_i,
  input  q16_t       eye_y_i,
  input  q16_t       eye_z_i,
  input  q16_t       aim_x_i,
  input  q16_t       aim_y_i,
  input  q16_t       aim_z_i,
  input  q16_t       upvec_x_i,
  input  q16_t       upvec_y_i,
  input  q16_t       upvec_z_i,
  output logic       result_valid_o,
  output logic [1:0] column_index_o,
  output q16_t       row0_value_o,
  output q16_t       row1_value_o,
  output q16_t       row2_value_o,
  output q16_t       row3_value_o,
  output logic       last_column_o,
  output logic       degenerate_o
);

  logic  push, q_full, q_valid, q_pop;
  pose_t pose_in, pose_head;

  lavm_front u_front (
    .start_i   (start_i),
    .eye_x_i   (eye_x_i),
    .eye_y_i   (eye_y_i),
    .eye_z_i   (eye_z_i),
    .aim_x_i   (aim_x_i),
    .aim_y_i   (aim_y_i),
    .aim_z_i   (aim_z_i),
    .upvec_x_i (upvec_x_i),
    .upvec_y_i (upvec_y_i),
    .upvec_z_i (upvec_z_i),
    .q_full_i  (q_full),
    .busy_o    (busy_o),
    .push_o    (push),
    .pose_o    (pose_in)
  );

  lavm_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .pose_i  (pose_in),
    .pop_i   (q_pop),
    .full_o  (q_full),
    .valid_o (q_valid),
    .head_o  (pose_head)
  );

  lavm_back u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .q_valid_i      (q_valid),
    .pose_i         (pose_head),
    .q_pop_o        (q_pop),
    .result_valid_o (result_valid_o),
    .column_index_o (column_index_o),
    .row0_value_o   (row0_value_o),
    .row1_value_o   (row1_value_o),
    .row2_value_o   (row2_value_o),
    .row3_value_o   (row3_value_o),
    .last_column_o  (last_column_o),
    .degenerate_o   (degenerate_o)
  );

`ifndef SYNTH
  // the last column is tagged and carries column three
  a_last_col: assert property (@(posedge clk_i) disable iff (!rst_ni)
    last_column_o |-> (result_valid_o && column_index_o == LAST_COL))
    else $error("last column tag on a non-final column");

  // columns of one matrix leave on consecutive cycles
  a_burst: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_valid_o && column_index_o != LAST_COL) |=>
      (result_valid_o && column_index_o == $past(column_index_o) + 2'd1))
    else $error("column burst broken");

  // degenerate flag holds across one matrix
  a_deg_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_valid_o && column_index_o != 2'd0) |-> $stable(degenerate_o))
    else $error("degenerate flag changed within a matrix");
`endif

endmodule

@@ verif/tb_look_at_view_matrix.sv @@
`timescale 1ns / 1ps
// Self-checking bench for look_at_view_matrix: random and directed poses, a local view
// matrix predictor, and per-column comparison. Depends on lavm_pkg and the block's RTL.
module tb_look_at_view_matrix;
  import lavm_pkg::*;

  typedef struct {
    q16_t eye [3];
    q16_t aim [3];
    q16_t upv [3];
  } pose_item_t;

  typedef struct {
    logic [1:0] col;
    q16_t       r0, r1, r2, r3;
    logic       last;
    logic       deg;
  } column_t;

  logic       clk_i = 1'b0;
  logic       rst_ni = 1'b0;
  logic       start_i = 1'b0;
  logic       busy_o;
  q16_t       eye_x_i = '0, eye_y_i = '0, eye_z_i = '0;
  q16_t       aim_x_i = '0, aim_y_i = '0, aim_z_i = '0;
  q16_t       upvec_x_i = '0, upvec_y_i = '0, upvec_z_i = '0;
  logic       result_valid_o;
  logic [1:0] column_index_o;
  q16_t       row0_value_o, row1_value_o, row2_value_o, row3_value_o;
  logic       last_column_o, degenerate_o;

  look_at_view_matrix DUT (.*);

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  pose_item_t pending_poses[$];
  column_t    expected_columns[$];
  int         mismatches = 0;
  int         cycle_count = 0;
  bit         drain_hold = 1'b0;
  bit         idle_off = 1'b0;
  bit         driving = 1'b0;
  bit         in_taken = 1'b0;
  int         gap_left = 0;

  // Unsigned magnitude of a signed 128-bit value.
  function automatic logic [127:0] mag128(logic signed [127:0] v);
    return v < 0 ? 128'(-v) : 128'(v);
  endfunction

  function automatic logic signed [127:0] round_away(logic signed [127:0] v, int n);
    logic [127:0] m;
    m = (mag128(v) + (128'd1 << (n - 1))) >> n;
    return v < 0 ? -$signed(m) : $signed(m);
  endfunction

  function automatic q16_t clamp_q16(logic signed [127:0] v);
    if (v > 128'sd2147483647) return 32'sh7FFF_FFFF;
    if (v < -128'sd2147483648) return 32'sh8000_0000;
    return v[31:0];
  endfunction

  function automatic logic [63:0] root64(logic [63:0] x);
    logic [63:0] res, bitv;
    res = 0;
    bitv = 64'd1 << 62;
    while (bitv > x) bitv >>= 2;
    while (bitv != 0) begin
      if (x >= res + bitv) begin
        x -= res + bitv;
        res = (res >> 1) + bitv;
      end else begin
        res >>= 1;
      end
      bitv >>= 2;
    end
    return res;
  endfunction

  // Scale to a unit vector in Q2.30; zero vector gives zeros and returns 0.
  function automatic bit unit_vec(input logic signed [127:0] v [3],
                                  output logic signed [127:0] o [3]);
    logic [127:0] mg [3];
    logic [127:0] m, sum, q;
    logic [63:0] len;
    int nb;
    m = 0;
    for (int i = 0; i < 3; i++) begin
      mg[i] = mag128(v[i]);
      if (mg[i] > m) m = mg[i];
    end
    if (m == 0) begin
      for (int i = 0; i < 3; i++) o[i] = 0;
      return 1'b0;
    end
    nb = 0;
    while ((m >> nb) != 0) nb++;
    sum = 0;
    for (int i = 0; i < 3; i++) begin
      if (nb > 31) mg[i] >>= (nb - 31);
      else if (nb < 31) mg[i] <<= (31 - nb);
      sum += mg[i] * mg[i];
    end
    len = root64(sum[63:0]);
    for (int i = 0; i < 3; i++) begin
      q = ((mg[i] << 30) + (len >> 1)) / len;
      o[i] = v[i] < 0 ? -$signed(q) : $signed(q);
    end
    return 1'b1;
  endfunction

  function automatic void cross3(input logic signed [127:0] a [3],
                                 input logic signed [127:0] b [3],
                                 output logic signed [127:0] c [3]);
    c[0] = a[1] * b[2] - a[2] * b[1];
    c[1] = a[2] * b[0] - a[0] * b[2];
    c[2] = a[0] * b[1] - a[1] * b[0];
  endfunction

  function automatic void predict_view_matrix(pose_item_t p);
    logic signed [127:0] e [3], up [3], d [3], f [3], s [3], u [3], w [3];
    logic signed [127:0] ds, du, df;
    column_t c;
    bit deg;
    for (int i = 0; i < 3; i++) begin
      e[i] = p.eye[i];
      up[i] = p.upv[i];
      d[i] = 128'(p.aim[i]) - 128'(p.eye[i]);
    end
    deg = !unit_vec(d, f);
    cross3(f, up, w);
    if (!unit_vec(w, s)) deg = 1'b1;
    cross3(s, f, w);
    for (int i = 0; i < 3; i++) u[i] = round_away(w[i], 30);
    for (int i = 0; i < 3; i++) begin
      c.col = 2'(i);
      c.r0 = 32'(round_away(s[i], 14));
      c.r1 = 32'(round_away(u[i], 14));
      c.r2 = 32'(-round_away(f[i], 14));
      c.r3 = '0;
      c.last = 1'b0;
      c.deg = deg;
      expected_columns.push_back(c);
    end
    ds = s[0] * e[0] + s[1] * e[1] + s[2] * e[2];
    du = u[0] * e[0] + u[1] * e[1] + u[2] * e[2];
    df = f[0] * e[0] + f[1] * e[1] + f[2] * e[2];
    c.col = LAST_COL;
    c.r0 = clamp_q16(-round_away(ds, 30));
    c.r1 = clamp_q16(-round_away(du, 30));
    c.r2 = clamp_q16(round_away(df, 30));
    c.r3 = ONE_Q16;
    c.last = 1'b1;
    c.deg = deg;
    expected_columns.push_back(c);
  endfunction

  function automatic q16_t rand_coord(int mode);
    case (mode)
      0: return q16_t'($urandom);
      1: return q16_t'($signed($urandom_range(0, 32'h000F_FFFF)) - 32'sh0008_0000);
      2: return q16_t'($signed($urandom_range(0, 32'h00FF_FFFF)) - 32'sh0080_0000);
      default: return q16_t'($urandom_range(0, 3) == 0 ? 32'h8000_0000 : 32'h7FFF_FFFF);
    endcase
  endfunction

  function automatic pose_item_t mk_pose(q16_t ex, q16_t ey, q16_t ez, q16_t ax, q16_t ay,
                                        q16_t az, q16_t ux, q16_t uy, q16_t uz);
    pose_item_t p;
    p.eye = '{ex, ey, ez};
    p.aim = '{ax, ay, az};
    p.upv = '{ux, uy, uz};
    return p;
  endfunction

  // Note at each rising edge whether the presented pose was taken.
  always @(posedge clk_i) begin
    in_taken <= start_i && !busy_o;
  end

  // Driver: present one pose per start, change inputs on the falling edge.
  always @(negedge clk_i) begin
    pose_item_t p;
    if (rst_ni) begin
      // advance only once the presented pose has been taken
      if (!start_i || in_taken) begin
        if (gap_left > 0) begin
          gap_left <= gap_left - 1;
          start_i <= 1'b0;
        end else if (pending_poses.size() != 0 && !drain_hold) begin
          p = pending_poses.pop_front();
          predict_view_matrix(p);
          {eye_x_i, eye_y_i, eye_z_i} <= {p.eye[0], p.eye[1], p.eye[2]};
          {aim_x_i, aim_y_i, aim_z_i} <= {p.aim[0], p.aim[1], p.aim[2]};
          {upvec_x_i, upvec_y_i, upvec_z_i} <= {p.upv[0], p.upv[1], p.upv[2]};
          start_i <= 1'b1;
          if (!idle_off && $urandom_range(0, 3) == 0) gap_left <= $urandom_range(1, 11);
        end else begin
          start_i <= 1'b0;
        end
      end
    end
  end

  // Monitor: compare each column with the oldest expectation.
  always @(posedge clk_i) begin
    column_t c;
    cycle_count <= cycle_count + 1;
    if (rst_ni && result_valid_o) begin
      if (expected_columns.size() == 0) begin
        mismatches <= mismatches + 1;
        if (mismatches < 10) $display("column %0d arrived with nothing expected", column_index_o);
      end else begin
        c = expected_columns.pop_front();
        if (c.col !== column_index_o || c.r0 !== row0_value_o || c.r1 !== row1_value_o ||
            c.r2 !== row2_value_o || c.r3 !== row3_value_o || c.last !== last_column_o ||
            c.deg !== degenerate_o) begin
          mismatches <= mismatches + 1;
          if (mismatches < 10)
            $display("mismatch exp col%0d %h %h %h %h l%b d%b got col%0d %h %h %h %h l%b d%b",
                     c.col, c.r0, c.r1, c.r2, c.r3, c.last, c.deg, column_index_o,
                     row0_value_o, row1_value_o, row2_value_o, row3_value_o,
                     last_column_o, degenerate_o);
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if (cycle_count > 600000) begin
      $display("look_at_view_matrix verification failed");
      $finish;
    end
  end

  initial begin
    int mode;
    pose_item_t p;
    q16_t mx, mn;
    mx = 32'sh7FFF_FFFF;
    mn = 32'sh8000_0000;
    // Directed: axis poses, extremes, degenerate forward and side, overflowing translation.
    pending_poses.push_back(mk_pose(0, 0, 65536*5, 0, 0, 0, 0, 65536, 0));
    pending_poses.push_back(mk_pose(65536, 2*65536, 3*65536, 65536, 2*65536, 3*65536,
                                    0, 65536, 0));
    pending_poses.push_back(mk_pose(0, 0, 0, 0, 0, 0, 0, 0, 0));
    pending_poses.push_back(mk_pose(mx, mx, mx, mx, mx, mx, mx, mx, mx));
    pending_poses.push_back(mk_pose(0, 0, 0, 0, 65536, 0, 0, 65536, 0));
    pending_poses.push_back(mk_pose(0, 0, 0, 0, 65536, 0, 0, -3*65536, 0));
    pending_poses.push_back(mk_pose(1, 2, 3, 4, 5, 6, 0, 0, 0));
    pending_poses.push_back(mk_pose(mn, mn, mn, mx, mx, mx, 0, 65536, 0));
    pending_poses.push_back(mk_pose(mx, mn, mx, mn, mx, mn, mn, mx, mn));
    pending_poses.push_back(mk_pose(mx, mx, mx, mn, mn, mn, mx, 0, 0));
    pending_poses.push_back(mk_pose(mn, mx, 0, mn, mx, 1, 1, 0, 0));
    pending_poses.push_back(mk_pose(mn, mn, mn, mn, mn, mx, mn, mx, 0));
    pending_poses.push_back(mk_pose(-1, -1, -1, 0, 0, 0, -1, 1, -1));
    pending_poses.push_back(mk_pose(0, 0, 0, mn, 0, 0, 0, 0, mn));
    pending_poses.push_back(mk_pose(32'sh0000_8000, -32'sh0000_8000, 7, -5, 9, 32'sh1234_5678,
                                    32'sh7654_3210, -32'sh0ABC_DEF0, 3));
    for (int i = 0; i < 215; i++) begin
      mode = $urandom_range(0, 9);
      for (int k = 0; k < 3; k++) begin
        p.eye[k] = rand_coord(mode < 3 ? 0 : (mode < 6 ? 1 : (mode < 9 ? 2 : 3)));
        p.aim[k] = rand_coord(mode < 3 ? 0 : (mode < 6 ? 1 : (mode < 9 ? 2 : 3)));
        p.upv[k] = rand_coord($urandom_range(0, 3));
      end
      // Occasionally force aim onto eye, or up along the view line.
      if ($urandom_range(0, 19) == 0) p.aim = p.eye;
      else if ($urandom_range(0, 19) == 0)
        for (int k = 0; k < 3; k++) p.upv[k] = p.aim[k] - p.eye[k];
      pending_poses.push_back(p);
    end
    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    // Hold the sender once until every expected column has come back.
    wait (pending_poses.size() <= 200);
    drain_hold = 1'b1;
    wait (expected_columns.size() == 0 && !start_i);
    drain_hold = 1'b0;
    wait (pending_poses.size() <= 60);
    idle_off = 1'b1;
    wait (pending_poses.size() == 0);
    @(negedge clk_i);
    wait (!start_i && expected_columns.size() == 0);
    repeat (400) @(posedge clk_i);
    if (mismatches == 0 && expected_columns.size() == 0) begin
      $display("look_at_view_matrix verification clean");
    end else begin
      $display("look_at_view_matrix verification failed");
    end
    $finish;
  end

endmodule

@@ files.f @@
hdl/lavm_pkg.sv
hdl/lavm_front.sv
hdl/lavm_queue.sv
hdl/lavm_back.sv
hdl/look_at_view_matrix.sv
verif/tb_look_at_view_matrix.sv
